FILE: design/sfd_pkg.sv
package sfd_pkg;

  localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
  localparam int          FRAME_LEN  = 7;
  localparam int          DATA_LEN   = FRAME_LEN - 1;
  localparam int          POS_W      = $clog2(FRAME_LEN);
  localparam logic [15:0] SPEED_BIAS = 16'h8000;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [7:0]         byte_t;
  typedef logic signed [15:0] speed_t;

  localparam pos_t LAST_POS = pos_t'(FRAME_LEN - 1);

  // collector status seen by the output side
  typedef struct packed {
    logic frame_last; // collector waits for the checksum word that closes the frame
  } status_t;

  typedef struct packed {
    logic   valid;
    speed_t speed_c;
    speed_t speed_b;
    speed_t speed_a;
  } result_t;

  // bias minus big-endian pair, wrapped to 16 bits
  function automatic speed_t speed_of(input byte_t hi, input byte_t lo);
    speed_of = speed_t'(SPEED_BIAS - {hi, lo});
  endfunction

endpackage

FILE: design/sfd_collector.sv
module sfd_collector
  import sfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    byte_take,
  input  byte_t   rx_byte,
  output status_t status,
  output result_t result
);

  logic  prev_sync, prev_sync_next;
  logic  in_frame, in_frame_next;
  pos_t  pos, pos_next;
  byte_t sum, sum_next;
  byte_t data [DATA_LEN];
  logic  store;
  logic  hit;

  always_comb begin
    prev_sync_next = prev_sync;
    in_frame_next  = in_frame;
    pos_next       = pos;
    sum_next       = sum;
    store          = 1'b0;
    hit            = 1'b0;
    if (byte_take) begin
      if (rx_byte == SYNC_BYTE && prev_sync) begin
        // sync pair, restart collection
        in_frame_next = 1'b1;
        pos_next      = '0;
      end else begin
        prev_sync_next = (rx_byte == SYNC_BYTE);
        if (in_frame) begin
          if (pos == LAST_POS) begin
            // checksum word closes the frame
            in_frame_next  = 1'b0;
            prev_sync_next = 1'b0;
            pos_next       = '0;
            hit            = (sum == rx_byte);
          end else begin
            store    = 1'b1;
            sum_next = (pos == '0) ? rx_byte : byte_t'(sum + rx_byte);
            pos_next = pos_t'(pos + pos_t'(1));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sync <= 1'b0;
      in_frame  <= 1'b0;
      pos       <= '0;
    end else begin
      prev_sync <= prev_sync_next;
      in_frame  <= in_frame_next;
      pos       <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
    if (store) begin
      data[pos] <= rx_byte;
    end
  end

  assign status.frame_last = in_frame && (pos == LAST_POS);

  assign result.valid   = hit;
  assign result.speed_a = speed_of(data[0], data[1]);
  assign result.speed_b = speed_of(data[2], data[3]);
  assign result.speed_c = speed_of(data[4], data[5]);

`ifndef NO_ASSERTIONS
  a_idle_pos_zero: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (pos == '0))
    else $error("position not zero while idle");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= LAST_POS)
    else $error("position beyond frame");

  a_frame_close: assert property (@(posedge clk) disable iff (rst)
    result.valid |=> (!in_frame && !prev_sync))
    else $error("frame not closed after result");
`endif

endmodule

FILE: design/sync_frame_deframer_checksum_unit.sv
// double sync byte deframer with additive checksum, one word per cycle
// latency: m_tvalid rises the cycle after the checksum word is accepted
// throughput: one input word per cycle; s_tready drops only for a frame
//   closing word while the output register holds an untaken result
// reset: rst synchronous active high, clears sync, frame and output valid
module sync_frame_deframer_checksum_unit
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // rx_byte[7:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // speed_a[15:0], speed_b[31:16], speed_c[47:32]
);

  status_t status;
  result_t result;
  logic    byte_take;
  logic    out_free;

  // output slot is free when empty or being drained this cycle
  assign out_free  = !m_tvalid || m_tready;
  // only a frame closing word can produce a result, so only it waits
  assign s_tready  = out_free || !status.frame_last;
  assign byte_take = s_tvalid && s_tready;

  sfd_collector u_collector (
    .clk       (clk),
    .rst       (rst),
    .byte_take (byte_take),
    .rx_byte   (s_tdata),
    .status    (status),
    .result    (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (result.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (result.valid) begin
      m_tdata <= {result.speed_c, result.speed_b, result.speed_a};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> out_free)
    else $error("result would overwrite an untaken word");

  a_result_from_word: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (byte_take && status.frame_last))
    else $error("result without a closing word");

  a_rise_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(byte_take && status.frame_last))
    else $error("output valid without a completed frame");
`endif

endmodule

FILE: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  // one result word as it sits on m_tdata, speed_a in the low bits
  typedef struct packed {
    speed_t spd_c;
    speed_t spd_b;
    speed_t spd_a;
  } speeds_t;

  // directed row: word to send, and a typed result where it is obvious
  typedef struct packed {
    byte_t   word;
    logic    has_exp;
    speeds_t exp;
  } dir_row_t;

  localparam int DIR_N = 24;
  localparam int RAND_PER_PHASE = 350;
  localparam int DRAIN_CYCLES = 8;

  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // idle word, dropped
    '{8'h00, 1'b0, 48'h0},
    // sync pair, one data word, then a second sync pair restarts (its first 0xff is stored as data)
    '{SYNC_BYTE, 1'b0, 48'h0},
    '{SYNC_BYTE, 1'b0, 48'h0},
    '{8'h05, 1'b0, 48'h0},
    '{SYNC_BYTE, 1'b0, 48'h0},
    '{SYNC_BYTE, 1'b0, 48'h0},
    // pairs 0x0000, 0x0001, 0x8000 give the most negative, the most positive and zero
    '{8'h00, 1'b0, 48'h0},
    '{8'h00, 1'b0, 48'h0},
    '{8'h00, 1'b0, 48'h0},
    '{8'h01, 1'b0, 48'h0},
    '{8'h80, 1'b0, 48'h0},
    '{8'h00, 1'b0, 48'h0},
    '{8'h81, 1'b1, {16'h0000, 16'h7FFF, 16'h8000}},
    // frame with a lone 0xff as data and a wrong checksum that is itself 0xff
    '{SYNC_BYTE, 1'b0, 48'h0},
    '{SYNC_BYTE, 1'b0, 48'h0},
    '{8'h00, 1'b0, 48'h0},
    '{SYNC_BYTE, 1'b0, 48'h0},
    '{8'h01, 1'b0, 48'h0},
    '{8'h00, 1'b0, 48'h0},
    '{8'h00, 1'b0, 48'h0},
    '{8'h00, 1'b0, 48'h0},
    '{SYNC_BYTE, 1'b0, 48'h0},
    // frame end cleared the sync flag, so this 0xff alone starts nothing
    '{SYNC_BYTE, 1'b0, 48'h0},
    '{8'h00, 1'b0, 48'h0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // rx_byte[7:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // speed_a[15:0], speed_b[31:16], speed_c[47:32]

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sync_frame_deframer_checksum_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // deframer state mirrored in the testbench
  logic  fr_sync = 1'b0;
  logic  fr_active = 1'b0;
  int    fr_pos = 0;
  byte_t fr_bytes [FRAME_LEN];

  speeds_t pending_speeds [$];   // speed triples still owed by the block
  speeds_t got;
  int      n_sent = 0;
  int      n_speeds = 0;
  int      err_cnt = 0;
  int      src_idle_pct = 0;
  int      snk_stall_pct = 0;

  task automatic report_err(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // feed one received word through the mirrored deframer, 1 when a triple comes out
  function automatic bit deframe_word(input byte_t w, output speeds_t r);
    byte_t sum;
    r = '0;
    // second 0xff in a row: (re)start collection, sync flag stays set
    if (w == SYNC_BYTE && fr_sync) begin
      fr_active = 1'b1;
      fr_pos = 0;
      return 1'b0;
    end
    fr_sync = (w == SYNC_BYTE);
    if (!fr_active) return 1'b0;
    fr_bytes[fr_pos] = w;
    fr_pos++;
    if (fr_pos != FRAME_LEN) return 1'b0;
    // frame closes whatever the checksum says
    fr_sync = 1'b0;
    fr_active = 1'b0;
    fr_pos = 0;
    sum = '0;
    for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + fr_bytes[i];
    if (sum != fr_bytes[FRAME_LEN-1]) return 1'b0;
    // bias minus big-endian pair, wrapping in 16 bits
    r.spd_a = 16'h8000 - {fr_bytes[0], fr_bytes[1]};
    r.spd_b = 16'h8000 - {fr_bytes[2], fr_bytes[3]};
    r.spd_c = 16'h8000 - {fr_bytes[4], fr_bytes[5]};
    return 1'b1;
  endfunction

  // push one word through the input handshake, then record what it owes
  task automatic send_word(input byte_t w, input logic has_exp, input speeds_t exp);
    speeds_t pred;
    bit      hit;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    n_sent++;
    hit = deframe_word(w, pred);
    if (has_exp) pending_speeds.push_back(exp);
    else if (hit) pending_speeds.push_back(pred);
  endtask

  // skewed toward the boundary values
  function automatic byte_t pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return SYNC_BYTE;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return byte_t'($urandom);
    endcase
  endfunction

  // mostly well formed frames, some cut short, some line noise
  task automatic run_random(input int n_words);
    int    stop_at;
    int    kind;
    int    len;
    byte_t w;
    byte_t sum;
    stop_at = n_sent + n_words;
    while (n_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        sum = '0;
        send_word(SYNC_BYTE, 1'b0, '0);
        send_word(SYNC_BYTE, 1'b0, '0);
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
          w = pick_byte();
          sum = sum + w;
          send_word(w, 1'b0, '0);
        end
        // roughly one frame in ten carries a corrupted checksum
        if ($urandom_range(9) == 0) sum = sum ^ byte_t'($urandom_range(255, 1));
        send_word(sum, 1'b0, '0);
      end else if (kind < 90) begin
        send_word(SYNC_BYTE, 1'b0, '0);
        send_word(SYNC_BYTE, 1'b0, '0);
        len = $urandom_range(8);
        for (int i = 0; i < len; i++) send_word(pick_byte(), 1'b0, '0);
      end else begin
        len = $urandom_range(4, 1);
        for (int i = 0; i < len; i++) send_word(pick_byte(), 1'b0, '0);
      end
    end
  endtask

  // hold the sender off until every owed triple has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk);
  endtask

  // receiver side stalls
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // result check, field by field against the oldest owed triple
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_speeds.size() == 0) begin
        report_err($sformatf("unexpected result a=%0d b=%0d c=%0d",
                             got.spd_a, got.spd_b, got.spd_c));
      end else begin
        speeds_t exp;
        exp = pending_speeds.pop_front();
        n_speeds++;
        if (got.spd_a !== exp.spd_a)
          report_err($sformatf("speed_a got %0d expected %0d", got.spd_a, exp.spd_a));
        if (got.spd_b !== exp.spd_b)
          report_err($sformatf("speed_b got %0d expected %0d", got.spd_b, exp.spd_b));
        if (got.spd_c !== exp.spd_c)
          report_err($sformatf("speed_c got %0d expected %0d", got.spd_c, exp.spd_c));
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase 0: sender gaps light, receiver stalls heavy
    src_idle_pct  = 33;
    snk_stall_pct = 86;
    for (int i = 0; i < DIR_N; i++)
      send_word(DIR_TAB[i].word, DIR_TAB[i].has_exp, DIR_TAB[i].exp);
    run_random(RAND_PER_PHASE);
    wait_drained();

    // phase 1: the other way round
    src_idle_pct  = 86;
    snk_stall_pct = 33;
    run_random(RAND_PER_PHASE);
    wait_drained();

    // phase 2: full rate both sides
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    run_random(RAND_PER_PHASE);
    wait_drained();

    // a short extra wait catches any stray output
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_speeds.size() != 0)
      report_err($sformatf("%0d speed triples never arrived", pending_speeds.size()));

    $display("sent %0d words (%0d directed), checked %0d speed triples",
             n_sent, DIR_N, n_speeds);
    $display("%s %s", "frames with restarts, bad checksums and truncation, plus noise,",
             "under three stall mixes");
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sync_frame_deframer_checksum_unit.f
design/sfd_pkg.sv
design/sfd_collector.sv
design/sync_frame_deframer_checksum_unit.sv
verif/tb_top.sv
